### hw/rtl/rtxq_pkg.sv
// Shared types, constants and helpers of the xterm 256-color quantizer.
// Used by the cube search, the gray search and the top level.
`default_nettype none

package rtxq_pkg;

   // Number of register stages in each candidate search path.
   localparam int unsigned SEARCH_DEPTH = 4;

   // Palette layout.
   localparam logic [7:0] CUBE_BASE       = 8'd16;
   localparam logic [7:0] CUBE_ROW_STRIDE = 8'd36;
   localparam logic [7:0] CUBE_COL_STRIDE = 8'd6;
   localparam logic [7:0] GRAY_BASE       = 8'd232;
   localparam logic [7:0] GRAY_FIRST_LVL  = 8'd8;
   localparam logic [7:0] GRAY_STEP       = 8'h0A;
   localparam logic [4:0] GRAY_LAST_K     = 5'd23;

   // Per-axis decision points; a value equal to a point rounds down.
   localparam logic [7:0] CUBE_SPLIT_0 = 8'd47;
   localparam logic [7:0] CUBE_SPLIT_1 = 8'd115;
   localparam logic [7:0] CUBE_SPLIT_2 = 8'd155;
   localparam logic [7:0] CUBE_SPLIT_3 = 8'd195;
   localparam logic [7:0] CUBE_SPLIT_4 = 8'd235;

   // Gray step index: k = floor((sum - 10) / 30), by reciprocal multiply.
   localparam logic [9:0]  GRAY_SUM_OFFSET = 10'd10;
   localparam logic [10:0] GRAY_RECIP      = 11'd1093;
   localparam int unsigned GRAY_SHIFT      = 15;

   typedef struct packed {
      logic [17:0] sq_dist;
      logic [7:0]  index;
   } cand_type;

   function automatic logic [7:0] cube_level(input logic [2:0] digit);
      logic [7:0] lvl;
      case (digit)
         3'd0:    lvl = 8'h00;
         3'd1:    lvl = 8'h5F;
         3'd2:    lvl = 8'h87;
         3'd3:    lvl = 8'hAF;
         3'd4:    lvl = 8'hD7;
         3'd5:    lvl = 8'hFF;
         default: lvl = 8'h00;
      endcase
      return lvl;
   endfunction

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rgb_to_xterm256_quantizer_unit.sv
// Top level of the xterm 256-color quantizer: pipeline control, final pick.
// Depends on rtxq_pkg, rtxq_cube_match and rtxq_gray_match.
//
// Usage:
//   req channel: one RGB pixel per item (req_red, req_green, req_blue).
//   rsp channel: one palette index (16..255) per item, in order.
//   Both channels use valid/ready; an item moves when both are high.
//
// The accepting edge loads the first of four stages of the cube and gray
// searches, which run side by side; the item then steps through the later
// stages to the last one and on into the output register that holds the
// winner and raises rsp_valid. Throughput is one item per cycle while the
// receiver does not stall; the stall-all pipeline advances every stage together.
//
// The cube candidate is exact per axis; the gray candidate comes from the
// channel sum through a reciprocal multiply. The cube wins on equal distance,
// since all its indices are lower.
//
// Reset clears every valid bit; data registers hold garbage until filled.
// When the receiver stalls with a result waiting, the whole pipe freezes,
// bubbles included, and req_ready drops until the result is taken.
`default_nettype none

module rgb_to_xterm256_quantizer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_palette_index
);
   import rtxq_pkg::*;

   logic                    advance;
   logic [SEARCH_DEPTH-1:0] valid_in;
   logic [SEARCH_DEPTH-1:0] valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_index_in;
   logic [7:0]              rsp_index_ff;
   cand_type                cube_cand;
   cand_type                gray_cand;

   // Advance whenever the output register is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   rtxq_cube_match u_cube (
      .clock   (clock),
      .advance (advance),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .cand    (cube_cand)
   );

   rtxq_gray_match u_gray (
      .clock   (clock),
      .advance (advance),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .cand    (gray_cand)
   );

   always_comb begin
      valid_in     = {valid_ff[SEARCH_DEPTH-2:0], req_valid};
      rsp_valid_in = valid_ff[SEARCH_DEPTH-1];
      // Prefer the cube on a tie: its indices are all below the gray ramp.
      rsp_index_in = (cube_cand.sq_dist <= gray_cand.sq_dist) ? cube_cand.index
                                                               : gray_cand.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result while the receiver stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted item lost at first stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (valid_ff == $past(valid_ff)) && $stable(rsp_index_ff))
      else $error("pipeline moved during stall");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_index_ff >= CUBE_BASE)
      else $error("result outside searched palette");

   a_empty_output_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input blocked with empty output");

endmodule

`default_nettype wire

### hw/rtl/rtxq_cube_match.sv
// Nearest entry of the 6x6x6 color cube, found axis by axis, with its distance.
// Four register stages; depends on rtxq_pkg.
`default_nettype none

module rtxq_cube_match (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic [7:0]         red,
   input  wire logic [7:0]         green,
   input  wire logic [7:0]         blue,
   output rtxq_pkg::cand_type      cand
);
   import rtxq_pkg::*;

   logic [7:0]  chan [3];
   logic [2:0]  s1_digit_in [3];
   logic [2:0]  s1_digit_ff [3];
   logic [7:0]  s1_chan_ff  [3];
   logic [7:0]  s2_diff_in  [3];
   logic [7:0]  s2_diff_ff  [3];
   logic [7:0]  s2_index_in;
   logic [7:0]  s2_index_ff;
   logic [15:0] s3_sq_in    [3];
   logic [15:0] s3_sq_ff    [3];
   logic [7:0]  s3_index_ff;
   cand_type    s4_cand_in;
   cand_type    s4_cand_ff;

   assign chan[0] = red;
   assign chan[1] = green;
   assign chan[2] = blue;

   // Each axis is independent; lowest level wins on a tie, giving the lowest index.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_digit_in[i] = 3'(chan[i] > CUBE_SPLIT_0) + 3'(chan[i] > CUBE_SPLIT_1)
                        + 3'(chan[i] > CUBE_SPLIT_2) + 3'(chan[i] > CUBE_SPLIT_3)
                        + 3'(chan[i] > CUBE_SPLIT_4);
         s2_diff_in[i]  = abs_diff(s1_chan_ff[i], cube_level(s1_digit_ff[i]));
         s3_sq_in[i]    = 16'(s2_diff_ff[i]) * 16'(s2_diff_ff[i]);
      end
      s2_index_in = CUBE_BASE + 8'(s1_digit_ff[0]) * CUBE_ROW_STRIDE
                  + 8'(s1_digit_ff[1]) * CUBE_COL_STRIDE + 8'(s1_digit_ff[2]);
      s4_cand_in.sq_dist = 18'(s3_sq_ff[0]) + 18'(s3_sq_ff[1]) + 18'(s3_sq_ff[2]);
      s4_cand_in.index   = s3_index_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s1_digit_ff[i] <= s1_digit_in[i];
            s1_chan_ff[i]  <= chan[i];
            s2_diff_ff[i]  <= s2_diff_in[i];
            s3_sq_ff[i]    <= s3_sq_in[i];
         end
         s2_index_ff <= s2_index_in;
         s3_index_ff <= s2_index_ff;
         s4_cand_ff  <= s4_cand_in;
      end
   end

   assign cand = s4_cand_ff;

endmodule

`default_nettype wire

### hw/rtl/rtxq_gray_match.sv
// Nearest entry of the 24-step gray ramp, from the channel sum, with its distance.
// Four register stages; depends on rtxq_pkg.
`default_nettype none

module rtxq_gray_match (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic [7:0]         red,
   input  wire logic [7:0]         green,
   input  wire logic [7:0]         blue,
   output rtxq_pkg::cand_type      cand
);
   import rtxq_pkg::*;

   logic [7:0]  chan [3];
   logic [9:0]  s1_sum_in;
   logic [9:0]  s1_sum_ff;
   logic [7:0]  s1_chan_ff [3];
   logic [9:0]  s2_offs;
   logic [20:0] s2_prod;
   logic [5:0]  s2_quot;
   logic [4:0]  s2_k_in;
   logic [4:0]  s2_k_ff;
   logic [7:0]  s2_chan_ff [3];
   logic [7:0]  s3_level;
   logic [7:0]  s3_diff_in [3];
   logic [7:0]  s3_diff_ff [3];
   logic [4:0]  s3_k_ff;
   cand_type    s4_cand_in;
   cand_type    s4_cand_ff;

   assign chan[0] = red;
   assign chan[1] = green;
   assign chan[2] = blue;

   always_comb begin
      s1_sum_in = 10'(red) + 10'(green) + 10'(blue);
      // Closest gray to the mean; a midpoint rounds to the darker step.
      s2_offs   = (s1_sum_ff > GRAY_SUM_OFFSET) ? (s1_sum_ff - GRAY_SUM_OFFSET) : '0;
      s2_prod   = 21'(s2_offs) * 21'(GRAY_RECIP);
      s2_quot   = s2_prod[GRAY_SHIFT +: 6];
      s2_k_in   = (s2_quot > 6'(GRAY_LAST_K)) ? GRAY_LAST_K : s2_quot[4:0];
      s3_level  = GRAY_FIRST_LVL + 8'(s2_k_ff) * GRAY_STEP;
      for (int i = 0; i < 3; i++) begin
         s3_diff_in[i] = abs_diff(s2_chan_ff[i], s3_level);
      end
      s4_cand_in.sq_dist = 18'(16'(s3_diff_ff[0]) * 16'(s3_diff_ff[0]))
                         + 18'(16'(s3_diff_ff[1]) * 16'(s3_diff_ff[1]))
                         + 18'(16'(s3_diff_ff[2]) * 16'(s3_diff_ff[2]));
      s4_cand_in.index   = GRAY_BASE + 8'(s3_k_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_ff <= s1_sum_in;
         s2_k_ff   <= s2_k_in;
         s3_k_ff   <= s2_k_ff;
         for (int i = 0; i < 3; i++) begin
            s1_chan_ff[i] <= chan[i];
            s2_chan_ff[i] <= s1_chan_ff[i];
            s3_diff_ff[i] <= s3_diff_in[i];
         end
         s4_cand_ff <= s4_cand_in;
      end
   end

   assign cand = s4_cand_ff;

endmodule

`default_nettype wire
